FILE: hdl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// Clock-time parser package
// Shared types, character codes and helper functions for the clock-time
// string parser.
// ----------------------------------------------------------------------------
package ctp_pkg;

  // Parse position within the string.
  typedef enum logic [2:0] {
    PH_LEAD      = 3'd0,
    PH_HOUR      = 3'd1,
    PH_MIN_FIRST = 3'd2,
    PH_MIN       = 3'd3,
    PH_SEC_FIRST = 3'd4,
    PH_SEC       = 3'd5,
    PH_TRAIL     = 3'd6,
    PH_SUFFIX    = 3'd7
  } phase_t;

  // Character codes.
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_P  = 8'h50;

  // Range limits and scale factors.
  localparam logic [4:0]  HOUR_SAT     = 5'd31;
  localparam logic [5:0]  MS_SAT       = 6'd63;
  localparam logic [5:0]  MS_LIMIT     = 6'd59;
  localparam logic [4:0]  HOUR_NOON    = 5'd12;
  localparam logic [4:0]  HOUR_DAY_MAX = 5'd23;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;

  // Suffix length codes; SUF_LONG means more than two characters.
  localparam logic [1:0] SUF_NONE = 2'd0;
  localparam logic [1:0] SUF_ONE  = 2'd1;
  localparam logic [1:0] SUF_TWO  = 2'd2;
  localparam logic [1:0] SUF_LONG = 2'd3;

  // Space, tab, LF, VT, FF or CR.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Only a..z are folded to upper case.
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

  // Append one decimal digit to the hour, saturating at its maximum.
  function automatic logic [4:0] acc_hour(input logic [4:0] acc, input logic [7:0] c);
    logic [8:0] v;
    v = 9'(acc) * 9'd10 + 9'(c[3:0]);
    return (v > 9'(HOUR_SAT)) ? HOUR_SAT : v[4:0];
  endfunction

  // Append one decimal digit to minutes or seconds, saturating at its maximum.
  function automatic logic [5:0] acc_ms(input logic [5:0] acc, input logic [7:0] c);
    logic [9:0] v;
    v = 10'(acc) * 10'd10 + 10'(c[3:0]);
    return (v > 10'(MS_SAT)) ? MS_SAT : v[5:0];
  endfunction

endpackage

FILE: hdl/ctp_if.sv
// ----------------------------------------------------------------------------
// Clock-time parser channels
// Valid/ready channel interfaces for the character input and the result.
// ----------------------------------------------------------------------------

// Character input channel.
interface ctp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// Parse result channel.
interface ctp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [16:0] day_seconds;

  modport source (output valid, output valid_res, output day_seconds, input ready);
  modport sink   (input valid, input valid_res, input day_seconds, output ready);
endinterface

FILE: hdl/clock_time_string_parser.sv
// ----------------------------------------------------------------------------
// Clock-time string parser
// Parses "hh:mm:ss [AM|PM]" strings one character at a time and returns
// seconds since midnight with a valid flag when the terminating zero arrives.
// ----------------------------------------------------------------------------
// The block accepts one character per clock cycle while no zero character
// waits on the result register. Each accepted character is held in an
// input register and folded from there into the parse state; a zero
// character ends the string, loads the result register and returns the
// parse state to its start, so the next string may follow without a gap.
// The result register is the only place where the input can be held up:
// a zero character waits in the input register, and holds up the
// characters behind it, while an earlier result has not been taken;
// other characters never wait.
module clock_time_string_parser
  import ctp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ctp_in_if.sink            in_chan,
  ctp_out_if.source         out_chan
);

  // Input register.
  logic       ch_vld_r;
  logic [7:0] ch_r;

  // Parse state.
  phase_t     phase_r, phase_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [1:0] suf_len_r, suf_len_nxt;
  logic [7:0] suf_first_r, suf_first_nxt;
  logic [7:0] suf_second_r, suf_second_nxt;
  logic       failed_r, failed_nxt;

  // Result register.
  logic        out_vld_r;
  logic        out_res_r;
  logic [16:0] out_sec_r;

  logic        out_free;
  logic        is_end;
  logic        advance;
  logic        res_ok;
  logic [16:0] res_sec;

  logic [4:0]  hour_adj;
  logic [7:0]  up_ch;

  // Handshake: a zero character needs a free result slot to move on.
  assign out_free      = !out_vld_r || out_chan.ready;
  assign is_end        = (ch_r == CH_END);
  assign advance       = ch_vld_r && (!is_end || out_free);
  assign in_chan.ready = !ch_vld_r || advance;

  assign out_chan.valid       = out_vld_r;
  assign out_chan.valid_res   = out_res_r;
  assign out_chan.day_seconds = out_sec_r;

  assign up_ch = to_upper(ch_r);

  // Input register capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      ch_vld_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      ch_r <= in_chan.ch;
    end
  end

  // Next parse state for the registered character.
  always_comb begin
    phase_nxt      = phase_r;
    hour_nxt       = hour_r;
    min_nxt        = min_r;
    sec_nxt        = sec_r;
    suf_len_nxt    = suf_len_r;
    suf_first_nxt  = suf_first_r;
    suf_second_nxt = suf_second_r;
    failed_nxt     = failed_r;

    if (is_end) begin
      phase_nxt      = PH_LEAD;
      hour_nxt       = '0;
      min_nxt        = '0;
      sec_nxt        = '0;
      suf_len_nxt    = SUF_NONE;
      suf_first_nxt  = '0;
      suf_second_nxt = '0;
      failed_nxt     = 1'b0;
    end else if (!failed_r) begin
      case (phase_r)
        PH_LEAD: begin
          if (is_digit(ch_r)) begin
            hour_nxt  = acc_hour(5'd0, ch_r);
            phase_nxt = PH_HOUR;
          end else if (!is_ws(ch_r)) begin
            failed_nxt = 1'b1;
          end
        end
        PH_HOUR: begin
          if (is_digit(ch_r)) begin
            hour_nxt = acc_hour(hour_r, ch_r);
          end else if (ch_r == CH_COLON) begin
            phase_nxt = PH_MIN_FIRST;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_MIN_FIRST, PH_MIN: begin
          if (is_digit(ch_r)) begin
            min_nxt   = acc_ms(min_r, ch_r);
            phase_nxt = PH_MIN;
          end else if ((phase_r == PH_MIN) && (ch_r == CH_COLON)) begin
            phase_nxt = PH_SEC_FIRST;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_SEC_FIRST: begin
          if (is_digit(ch_r)) begin
            sec_nxt   = acc_ms(6'd0, ch_r);
            phase_nxt = PH_SEC;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_SEC, PH_TRAIL, PH_SUFFIX: begin
          if ((phase_r == PH_SEC) && is_digit(ch_r)) begin
            sec_nxt = acc_ms(sec_r, ch_r);
          end else if ((phase_r != PH_SUFFIX) && is_ws(ch_r)) begin
            phase_nxt = PH_TRAIL;
          end else begin
            // Every remaining character belongs to the suffix.
            phase_nxt = PH_SUFFIX;
            case (suf_len_r)
              SUF_NONE: begin
                suf_first_nxt = up_ch;
                suf_len_nxt   = SUF_ONE;
              end
              SUF_ONE: begin
                suf_second_nxt = up_ch;
                suf_len_nxt    = SUF_TWO;
              end
              default: begin
                suf_len_nxt = SUF_LONG;
              end
            endcase
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  // Final check and conversion to seconds since midnight.
  always_comb begin
    res_ok   = !failed_r &&
               ((phase_r == PH_SEC) || (phase_r == PH_TRAIL) || (phase_r == PH_SUFFIX)) &&
               (min_r <= MS_LIMIT) && (sec_r <= MS_LIMIT);
    hour_adj = hour_r;
    if (suf_len_r != SUF_NONE) begin
      if (!((suf_len_r == SUF_ONE) ||
            ((suf_len_r == SUF_TWO) && (suf_second_r == CH_UP_M))) ||
          (hour_r < 5'd1) || (hour_r > HOUR_NOON)) begin
        res_ok = 1'b0;
      end
      if (suf_first_r == CH_UP_P) begin
        if (hour_r < HOUR_NOON) begin
          hour_adj = hour_r + HOUR_NOON;
        end
      end else if (suf_first_r == CH_UP_A) begin
        if (hour_r == HOUR_NOON) begin
          hour_adj = 5'd0;
        end
      end else begin
        res_ok = 1'b0;
      end
    end else if (hour_r > HOUR_DAY_MAX) begin
      res_ok = 1'b0;
    end
    res_sec = 17'(hour_adj) * SEC_PER_HOUR + 17'(min_r) * SEC_PER_MIN + 17'(sec_r);
  end

  // Parse state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      hour_r       <= '0;
      min_r        <= '0;
      sec_r        <= '0;
      suf_len_r    <= SUF_NONE;
      suf_first_r  <= '0;
      suf_second_r <= '0;
      failed_r     <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      hour_r       <= hour_nxt;
      min_r        <= min_nxt;
      sec_r        <= sec_nxt;
      suf_len_r    <= suf_len_nxt;
      suf_first_r  <= suf_first_nxt;
      suf_second_r <= suf_second_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // Result register: loaded by the end of a string, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && is_end) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
    if (advance && is_end) begin
      out_res_r <= res_ok;
      out_sec_r <= res_ok ? res_sec : 17'd0;
    end
  end

endmodule
